// ----- rtl/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// Profile resampler package
// Shared constants, status codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int RAW_BITS = 13;
  localparam int OUT_BITS = 16;
  localparam int CNT_BITS = 17;
  localparam int BIN_BITS = 7;
  localparam int DEF_MAX_RAW = 4096;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_BIN = 62;
  localparam int POINT_BITS = 32;

  localparam logic [1:0] REG_RAW_COUNT = 2'd0;
  localparam logic [1:0] REG_OUT_COUNT = 2'd1;
  localparam logic [1:0] REG_INTERP_MODE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FALLING = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;

  typedef struct packed {
    logic restart;
    logic size_start;
    logic size_step;
    logic take_sample;
    logic div_start;
    logic div_step;
    logic seg_init;
    logic emit_seg;
    logic emit_stair;
    logic emit_last;
    logic emit_bad;
    logic show_seg;
    logic show_stair;
    logic show_last;
    logic finish;
  } ppr_cmd_t;

  typedef struct packed {
    logic size_done;
    logic sizes_ok;
    logic div_done;
    logic seg_more;
    logic seg_final;
    logic stair_more;
    logic stair_final;
    logic last;
    logic first;
    logic linear;
  } ppr_stat_t;

endpackage

// ----- rtl/ppr_datapath.sv -----
// ----------------------------------------------------------------------------
// Profile resampler datapath
// Size check divider, slope divider, bin spreading and point generation.
// ----------------------------------------------------------------------------
module ppr_datapath #(
  parameter int MAX_RAW = ppr_pkg::DEF_MAX_RAW,
  parameter int VALUE_BITS = ppr_pkg::DEF_VALUE_BITS,
  parameter int MAX_BIN = ppr_pkg::DEF_MAX_BIN
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [31:0] sample_value,
  input  ppr_pkg::ppr_cmd_t cmd,
  output ppr_pkg::ppr_stat_t stat,
  output logic [31:0] res_value,
  output logic [15:0] res_index,
  output logic res_done,
  output logic [1:0] res_status
);
  import ppr_pkg::*;

  localparam int DIV_BITS = VALUE_BITS + 16;
  localparam int DC_BITS = $clog2(DIV_BITS + 1);

  logic [RAW_BITS-1:0] raw_count;
  logic [OUT_BITS-1:0] out_count;
  logic interp_mode;

  // Base bin and spare count, found by restoring division.
  logic [OUT_BITS-1:0] q_reg;
  logic [RAW_BITS:0] r_reg;
  logic [4:0] sz_cnt;
  logic [OUT_BITS-1:0] base;
  logic [RAW_BITS-1:0] spare_total;
  logic sizes_ok;
  logic [RAW_BITS:0] r_shift;
  logic [RAW_BITS+1:0] r_try;

  logic [RAW_BITS-1:0] sample_index;
  logic [VALUE_BITS-1:0] previous_sample;
  logic [CNT_BITS-1:0] emitted_count;
  logic [RAW_BITS:0] spread_acc;
  logic [RAW_BITS-1:0] spares_left;
  logic [BIN_BITS-1:0] previous_bin;

  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] y1;
  logic [BIN_BITS-1:0] seg_count;
  logic [BIN_BITS-1:0] xi;
  logic [1:0] seg_status;
  logic [DIV_BITS-1:0] dividend;
  logic [DIV_BITS-1:0] quot;
  logic [BIN_BITS:0] rem;
  logic [DC_BITS-1:0] div_cnt;
  logic [BIN_BITS+1:0] rem_try;
  logic [BIN_BITS:0] rem_shift;
  logic [DIV_BITS-1:0] acc;

  logic [RAW_BITS:0] acc_sum;
  logic take_spare;
  logic [BIN_BITS-1:0] bin_next;
  logic [VALUE_BITS-1:0] x_in;

  assign x_in = VALUE_BITS'(sample_value);
  assign r_shift = {r_reg[RAW_BITS-1:0], q_reg[OUT_BITS-1]};
  assign r_try = {1'b0, r_shift} - {2'b00, raw_count};
  assign rem_shift = {rem[BIN_BITS-1:0], dividend[DIV_BITS-1]};
  assign rem_try = {1'b0, rem_shift} - {2'b00, seg_count};

  assign acc_sum = spread_acc + {1'b0, spare_total};
  assign take_spare = (spares_left > RAW_BITS'(1)) && (acc_sum >= {1'b0, raw_count});
  assign bin_next = BIN_BITS'(base) + BIN_BITS'(take_spare);

  assign stat.size_done = (sz_cnt == 5'd16);
  assign stat.sizes_ok = sizes_ok;
  assign stat.div_done = (div_cnt == DC_BITS'(DIV_BITS));
  assign stat.seg_more = (xi < seg_count) &&
    !((sample_index != '0) && (emitted_count >= {1'b0, out_count}));
  assign stat.seg_final = (xi + BIN_BITS'(1) == seg_count) ||
    ((sample_index != '0) && (emitted_count + CNT_BITS'(1) >= {1'b0, out_count}));
  assign stat.stair_more = ({9'd0, xi} < base);
  assign stat.stair_final = ({9'd0, xi} + 16'd1 == base);
  assign stat.last = ({1'b0, sample_index} + 14'd1 >= {1'b0, raw_count});
  assign stat.first = (sample_index == '0);
  assign stat.linear = !interp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count <= RAW_BITS'(2);
      out_count <= OUT_BITS'(2);
      interp_mode <= 1'b0;
      sz_cnt <= 5'd0;
      sizes_ok <= 1'b0;
      sample_index <= '0;
      previous_sample <= '0;
      emitted_count <= '0;
      spread_acc <= '0;
      previous_bin <= '0;
      div_cnt <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RAW_COUNT: raw_count <= cfg_data[RAW_BITS-1:0];
          REG_OUT_COUNT: out_count <= cfg_data;
          REG_INTERP_MODE: interp_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.size_start) begin
        q_reg <= out_count;
        r_reg <= '0;
        sz_cnt <= 5'd0;
      end else if (cmd.size_step) begin
        if (!r_try[RAW_BITS+1]) begin
          r_reg <= r_try[RAW_BITS:0];
          q_reg <= {q_reg[OUT_BITS-2:0], 1'b1};
        end else begin
          r_reg <= r_shift;
          q_reg <= {q_reg[OUT_BITS-2:0], 1'b0};
        end
        sz_cnt <= sz_cnt + 5'd1;
        if (sz_cnt == 5'd15) begin
          sizes_ok <= (raw_count >= RAW_BITS'(2)) &&
            ({4'd0, raw_count} <= 17'(MAX_RAW)) && (out_count >= {3'd0, raw_count}) &&
            ({q_reg[OUT_BITS-2:0], !r_try[RAW_BITS+1]} <= OUT_BITS'(MAX_BIN));
        end
      end
      if (cmd.restart) begin
        sample_index <= '0;
        previous_sample <= '0;
        emitted_count <= '0;
        spread_acc <= '0;
        previous_bin <= '0;
        spares_left <= spare_total;
      end
      if (cmd.take_sample) begin
        x <= x_in;
        xi <= '0;
        seg_status <= ST_OK;
        if (!interp_mode) begin
          if (sample_index == '0) begin
            y1 <= '0;
            seg_count <= bin_next;
            previous_bin <= bin_next;
            spread_acc <= take_spare ? acc_sum - {1'b0, raw_count} :
              (spares_left > RAW_BITS'(1) ? acc_sum : spread_acc);
            if (take_spare) spares_left <= spares_left - RAW_BITS'(1);
          end else begin
            y1 <= previous_sample;
            seg_count <= previous_bin;
            if (x_in < previous_sample) seg_status <= ST_FALLING;
          end
        end
      end
      if (cmd.div_start) begin
        dividend <= (x > y1) ? DIV_BITS'(x - y1) << 16 : '0;
        rem <= '0;
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        if (!rem_try[BIN_BITS+1]) begin
          rem <= rem_try[BIN_BITS:0];
          dividend <= {dividend[DIV_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          dividend <= {dividend[DIV_BITS-2:0], 1'b0};
        end
        div_cnt <= div_cnt + DC_BITS'(1);
      end
      if (cmd.seg_init) begin
        quot <= dividend;
        acc <= {y1, 16'd0};
      end
      if (cmd.emit_seg) begin
        acc <= acc + quot;
        xi <= xi + BIN_BITS'(1);
        emitted_count <= emitted_count + CNT_BITS'(1);
      end
      if (cmd.emit_stair) begin
        xi <= xi + BIN_BITS'(1);
        emitted_count <= emitted_count + CNT_BITS'(1);
      end
      if (cmd.emit_last) begin
        emitted_count <= emitted_count + CNT_BITS'(1);
      end
      if (cmd.finish && !stat.last) begin
        previous_sample <= x;
        sample_index <= sample_index + RAW_BITS'(1);
        if (!interp_mode && sample_index != '0) begin
          previous_bin <= bin_next;
          spread_acc <= take_spare ? acc_sum - {1'b0, raw_count} :
            (spares_left > RAW_BITS'(1) ? acc_sum : spread_acc);
          if (take_spare) spares_left <= spares_left - RAW_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sz_cnt == 5'd16) begin
      base <= q_reg;
      spare_total <= r_reg[RAW_BITS-1:0];
    end
  end

  always_comb begin
    res_value = '0;
    res_done = 1'b0;
    res_status = ST_OK;
    if (cmd.emit_bad) begin
      res_status = ST_BAD_SIZE;
    end else if (cmd.show_seg) begin
      res_value = 32'(acc[DIV_BITS-1:16]);
      res_status = seg_status;
    end else if (cmd.show_stair) begin
      res_value = 32'(x);
    end else if (cmd.show_last) begin
      res_value = 32'(x);
      res_done = 1'b1;
      res_status = seg_status;
    end
  end
  assign res_index = cmd.emit_bad ? 16'd0 : emitted_count[15:0];

endmodule

// ----- rtl/ppr_control.sv -----
// ----------------------------------------------------------------------------
// Profile resampler controller
// Sequences size checking, sample intake, slope division and point output.
// ----------------------------------------------------------------------------
module ppr_control (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic sample_valid,
  output logic sample_ready,
  output logic point_valid,
  input  logic point_ready,
  output logic point_last,
  input  ppr_pkg::ppr_stat_t stat,
  output ppr_pkg::ppr_cmd_t cmd
);
  import ppr_pkg::*;

  typedef enum logic [3:0] {
    S_SIZE_START, S_SIZE, S_RESTART, S_IDLE, S_DIV_START, S_DIV, S_SEG_INIT,
    S_SEG, S_STAIR, S_LAST, S_BAD, S_FINISH
  } state_t;

  state_t state;
  logic fire;

  assign sample_ready = (state == S_IDLE) && !cfg_write;
  assign fire = point_valid && point_ready;

  always_comb begin
    cmd = '0;
    point_valid = 1'b0;
    point_last = 1'b0;
    unique case (state)
      S_SIZE_START: cmd.size_start = 1'b1;
      S_SIZE: cmd.size_step = !stat.size_done;
      S_RESTART: cmd.restart = 1'b1;
      S_IDLE: cmd.take_sample = sample_valid && stat.sizes_ok && !cfg_write;
      S_DIV_START: cmd.div_start = 1'b1;
      S_DIV: cmd.div_step = !stat.div_done;
      S_SEG_INIT: cmd.seg_init = 1'b1;
      S_SEG: begin
        point_valid = stat.seg_more;
        cmd.show_seg = 1'b1;
        cmd.emit_seg = fire;
        point_last = stat.seg_final && !stat.last;
      end
      S_STAIR: begin
        point_valid = stat.stair_more;
        cmd.show_stair = 1'b1;
        cmd.emit_stair = fire;
        point_last = stat.stair_final && !stat.last;
      end
      S_LAST: begin
        point_valid = 1'b1;
        point_last = 1'b1;
        cmd.show_last = 1'b1;
        cmd.emit_last = fire;
      end
      S_BAD: begin
        point_valid = 1'b1;
        point_last = 1'b1;
        cmd.emit_bad = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        cmd.restart = stat.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SIZE_START;
    end else if (cfg_write) begin
      state <= S_SIZE_START;
    end else begin
      unique case (state)
        S_SIZE_START: state <= S_SIZE;
        S_SIZE: if (stat.size_done) state <= S_RESTART;
        S_RESTART: state <= S_IDLE;
        S_IDLE: begin
          if (sample_valid) begin
            if (!stat.sizes_ok) state <= S_BAD;
            else if (stat.linear) state <= S_DIV_START;
            else state <= S_STAIR;
          end
        end
        S_DIV_START: state <= S_DIV;
        S_DIV: if (stat.div_done) state <= S_SEG_INIT;
        S_SEG_INIT: state <= S_SEG;
        S_SEG: begin
          if (!stat.seg_more) state <= stat.last ? S_LAST : S_FINISH;
        end
        S_STAIR: begin
          if (!stat.stair_more) state <= stat.last ? S_LAST : S_FINISH;
        end
        S_LAST: if (fire) state <= S_FINISH;
        S_BAD: if (fire) state <= S_IDLE;
        S_FINISH: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/profile_piecewise_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// Profile piecewise resampler
// In linear mode a request passes through intake, a bit-serial slope divider
// of VALUE_BITS + 16 steps and point output at one point per cycle while
// ready_out is high, with hand-offs between them. In staircase mode it skips
// the divider and repeats the sample value for base bin points. The last
// sample of a profile adds one point. After reset and after each register
// write the block runs a divider that finds the base bin before it accepts a
// request.
// ----------------------------------------------------------------------------
module profile_piecewise_resampler_unit #(
  parameter int MAX_RAW = ppr_pkg::DEF_MAX_RAW,
  parameter int VALUE_BITS = ppr_pkg::DEF_VALUE_BITS,
  parameter int MAX_BIN = ppr_pkg::DEF_MAX_BIN
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic valid_in,
  output logic ready_in,
  input  logic [31:0] sample_value,
  output logic valid_out,
  input  logic ready_out,
  output logic [31:0] point_value,
  output logic [15:0] point_index,
  output logic run_last,
  output logic profile_done,
  output logic [1:0] status
);
  import ppr_pkg::*;

  ppr_cmd_t cmd;
  ppr_stat_t stat;
  logic last_flag;
  logic valid_c;
  logic [31:0] value_c;
  logic [15:0] index_c;
  logic done_c;
  logic [1:0] status_c;

  ppr_control u_control (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .sample_valid(valid_in),
    .sample_ready(ready_in), .point_valid(valid_c), .point_ready(ready_out),
    .point_last(last_flag), .stat(stat), .cmd(cmd)
  );

  ppr_datapath #(.MAX_RAW(MAX_RAW), .VALUE_BITS(VALUE_BITS), .MAX_BIN(MAX_BIN)) u_datapath (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample_value(sample_value), .cmd(cmd), .stat(stat),
    .res_value(value_c), .res_index(index_c), .res_done(done_c), .res_status(status_c)
  );

  assign valid_out = valid_c;
  assign point_value = value_c;
  assign point_index = index_c;
  assign profile_done = done_c;
  assign status = status_c;
  assign run_last = last_flag;

endmodule
